@@ rtl/pnic_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pnic_pkg
// Shared types and constants for the Poisson noise inverse-CDF block.
// ----------------------------------------------------------------------------
package pnic_pkg;

    // Default table depth.
    localparam int MAX_BINS_DEF = 64;

    // Fixed field widths.
    localparam int DATA_W   = 16;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 6;
    localparam int OUT_W    = 24;
    localparam int SUM_W    = DATA_W + 1;
    localparam int PROD_W   = DATA_W + SUM_W;
    localparam int FRAC_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Configuration register reset values.
    localparam logic [DATA_W-1:0] GAIN_RESET = 16'd256;
    localparam logic [CNT_W-1:0]  BINS_RESET = 7'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE   = 1'b1;

    // Item commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Search sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HAND
    } srch_state_t;

    // Request from the search sequencer to the scaling stage.
    typedef struct packed {
        logic                valid;
        logic [CNT_W-1:0]    count;
        logic [DATA_W-1:0]   pixel;
    } scale_req_t;

endpackage : pnic_pkg
`default_nettype wire

@@ rtl/pnic_cdf_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pnic_cdf_mem
// Cumulative-probability table: one write port, one read port, registered
// read data, valid in the cycle after the read.
// ----------------------------------------------------------------------------
module pnic_cdf_mem
    import pnic_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
)
(
    input  wire                          clk,
    input  wire                          wr_en,
    input  wire [$clog2(MAX_BINS)-1:0]   wr_addr,
    input  wire [DATA_W-1:0]             wr_data,
    input  wire                          rd_en,
    input  wire [$clog2(MAX_BINS)-1:0]   rd_addr,
    output logic [DATA_W-1:0]            rd_data
);

    logic [DATA_W-1:0] mem [MAX_BINS];
    logic [DATA_W-1:0] rd_data_reg;

    // Table write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered table read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : pnic_cdf_mem
`default_nettype wire

@@ rtl/pnic_search.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pnic_search
// Input sequencer: writes table loads and scans the table for the first bin
// whose CDF entry exceeds the random fraction, one entry per cycle.
// ----------------------------------------------------------------------------
module pnic_search
    import pnic_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    // Input channel.
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          command,
    input  wire [IDX_W-1:0]              bin_index,
    input  wire [DATA_W-1:0]             pixel_value,
    input  wire [DATA_W-1:0]             random_fraction,
    // Configuration.
    input  wire [CNT_W-1:0]              bins_in_use,
    // Table ports.
    output logic                         wr_en,
    output logic [$clog2(MAX_BINS)-1:0]  wr_addr,
    output logic                         rd_en,
    output logic [$clog2(MAX_BINS)-1:0]  rd_addr,
    input  wire [DATA_W-1:0]             rd_data,
    // Scaling stage.
    output scale_req_t                   req,
    input  wire                          scale_ready
);

    localparam int AW = $clog2(MAX_BINS);
    localparam int JW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam logic [JW-1:0] MAX_J = JW'(MAX_BINS);

    srch_state_t       state_reg, state_next;
    logic [JW-1:0]     probe_reg, probe_next;
    logic [JW-1:0]     limit_reg, limit_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] rand_reg, rand_next;
    logic [DATA_W-1:0] pixel_reg, pixel_next;

    logic [JW-1:0]     bins_ext;
    logic [JW-1:0]     limit_in;
    logic [JW-1:0]     idx_ext;
    logic [JW-1:0]     probe_inc;
    logic              in_xfer;

    // Active bin count clipped to the table depth.
    assign bins_ext  = JW'(bins_in_use);
    assign limit_in  = (bins_ext > MAX_J) ? MAX_J : bins_ext;
    assign idx_ext   = JW'(bin_index);
    assign probe_inc = probe_reg + 1'b1;
    assign in_xfer   = in_valid && in_ready;

    // Loads outside the table are dropped.
    assign wr_en   = in_xfer && (command == CMD_LOAD) && (idx_ext < MAX_J);
    assign wr_addr = idx_ext[AW-1:0];

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Item payload and scan position.
    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        limit_reg <= limit_next;
        count_reg <= count_next;
        rand_reg  <= rand_next;
        pixel_reg <= pixel_next;
    end

    // Next state and outputs.
    always_comb
    begin
        state_next = state_reg;
        probe_next = probe_reg;
        limit_next = limit_reg;
        count_next = count_reg;
        rand_next  = rand_reg;
        pixel_next = pixel_reg;
        in_ready   = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = probe_inc[AW-1:0];
        req.valid  = 1'b0;
        req.count  = count_reg;
        req.pixel  = pixel_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_xfer && (command == CMD_PIXEL))
                begin
                    pixel_next = pixel_value;
                    rand_next  = random_fraction;
                    limit_next = limit_in;
                    probe_next = '0;
                    if (limit_in == '0)
                    begin
                        // No active bins: the sample is zero.
                        count_next = '0;
                        state_next = S_HAND;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Read data belongs to the entry at probe_reg.
                if (rd_data > rand_reg)
                begin
                    count_next = probe_reg[CNT_W-1:0];
                    state_next = S_HAND;
                end
                else if (probe_inc == limit_reg)
                begin
                    count_next = limit_reg[CNT_W-1:0];
                    state_next = S_HAND;
                end
                else
                begin
                    rd_en      = 1'b1;
                    probe_next = probe_inc;
                end
            end

            S_HAND:
            begin
                req.valid = 1'b1;
                if (scale_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule : pnic_search
`default_nettype wire

@@ rtl/pnic_scale.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pnic_scale
// Applies the Q8.8 exposure gain to pixel plus noise count, saturates the
// integer part to 24 bits and holds the result in the output register.
// ----------------------------------------------------------------------------
module pnic_scale
    import pnic_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire scale_req_t      req,
    output logic                 scale_ready,
    input  wire [DATA_W-1:0]     exposure_gain,
    // Output channel.
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [OUT_W-1:0]     noisy_pixel,
    output logic [CNT_W-1:0]     noise_count,
    output logic                 saturated
);

    logic                       mul_valid_reg, mul_valid_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [CNT_W-1:0]           mul_count_reg, mul_count_next;
    logic                       out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]           noisy_reg, noisy_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       sat_reg, sat_next;

    logic [SUM_W-1:0]           sum;
    logic [PROD_W-FRAC_W-1:0]   scaled;
    logic                       take_req;
    logic                       load_out;

    assign scale_ready = !mul_valid_reg;
    assign take_req    = req.valid && !mul_valid_reg;
    assign load_out    = mul_valid_reg && (!out_valid_reg || out_ready);

    // Multiply stage.
    assign sum    = SUM_W'(req.pixel) + SUM_W'(req.count);
    assign scaled = prod_reg[PROD_W-1:FRAC_W];

    always_comb
    begin
        mul_valid_next = mul_valid_reg;
        prod_next      = prod_reg;
        mul_count_next = mul_count_reg;
        if (load_out)
        begin
            mul_valid_next = 1'b0;
        end
        if (take_req)
        begin
            mul_valid_next = 1'b1;
            prod_next      = PROD_W'(exposure_gain) * PROD_W'(sum);
            mul_count_next = req.count;
        end
    end

    // Saturation into the output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        noisy_next     = noisy_reg;
        count_next     = count_reg;
        sat_next       = sat_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            sat_next       = scaled[PROD_W-FRAC_W-1];
            noisy_next     = scaled[PROD_W-FRAC_W-1] ? OUT_MAX : scaled[OUT_W-1:0];
            count_next     = mul_count_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        mul_count_reg <= mul_count_next;
        noisy_reg     <= noisy_next;
        count_reg     <= count_next;
        sat_reg       <= sat_next;
    end

    assign out_valid   = out_valid_reg;
    assign noisy_pixel = noisy_reg;
    assign noise_count = count_reg;
    assign saturated   = sat_reg;

endmodule : pnic_scale
`default_nettype wire

@@ rtl/poisson_noise_inverse_cdf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// poisson_noise_inverse_cdf
// Adds Poisson noise to pixels by inverse-CDF table lookup and applies a
// Q8.8 exposure gain, saturating the result to 24 bits.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries two kinds of items. A load item (command 0)
//   writes one CDF entry into the table and gives no result. A pixel item
//   (command 1) scans the table from bin 0, one entry per cycle through the
//   single read port, until an entry exceeds the random fraction or the
//   active bin count is reached.
//   The output channel gives one transfer per pixel item.
//   The input channel takes no new item until a pixel's scan has ended
//   and its result has been handed to the scaling stage.
//   The configuration channel is always ready and writes exposure_gain
//   (index 0) or bins_in_use (index 1, low 7 bits of the data).
//   Reset sets the gain to 1.0 and the bin count to zero; table entries
//   hold nothing until loaded and must be loaded before a scan reaches them.
//   A result that waits in the output register does not block loads or the
//   scan of the next pixel; only its move into the output register waits.
// ----------------------------------------------------------------------------
module poisson_noise_inverse_cdf
    import pnic_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    // Configuration channel.
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [DATA_W-1:0]     cfg_data,
    // Input channel.
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire                  command,
    input  wire [IDX_W-1:0]      bin_index,
    input  wire [DATA_W-1:0]     cdf_value,
    input  wire [DATA_W-1:0]     pixel_value,
    input  wire [DATA_W-1:0]     random_fraction,
    // Output channel.
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [OUT_W-1:0]     noisy_pixel,
    output logic [CNT_W-1:0]     noise_count,
    output logic                 saturated
);

    localparam int AW = $clog2(MAX_BINS);

    logic [DATA_W-1:0] gain_reg, gain_next;
    logic [CNT_W-1:0]  bins_reg, bins_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    scale_req_t        req;
    logic              scale_ready;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        gain_next = gain_reg;
        bins_next = bins_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EXPOSURE_GAIN: gain_next = cfg_data;
                REG_BINS_IN_USE:   bins_next = cfg_data[CNT_W-1:0];
                default:           gain_next = gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            bins_reg <= BINS_RESET;
        end
        else
        begin
            gain_reg <= gain_next;
            bins_reg <= bins_next;
        end
    end

    // CDF table.
    pnic_cdf_mem #(
        .MAX_BINS (MAX_BINS)
    ) u_cdf_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cdf_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Load handling and table scan.
    pnic_search #(
        .MAX_BINS (MAX_BINS)
    ) u_search (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .bin_index       (bin_index),
        .pixel_value     (pixel_value),
        .random_fraction (random_fraction),
        .bins_in_use     (bins_reg),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .req             (req),
        .scale_ready     (scale_ready)
    );

    // Gain, saturation and output register.
    pnic_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .scale_ready   (scale_ready),
        .exposure_gain (gain_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .noisy_pixel   (noisy_pixel),
        .noise_count   (noise_count),
        .saturated     (saturated)
    );

endmodule : poisson_noise_inverse_cdf
`default_nettype wire
